### design/block_buffer_cache_allocator_macros.svh
// Assertion macros for the buffer cache allocator RTL.
// No dependencies; include once per asserting module.
`ifndef BLOCK_BUFFER_CACHE_ALLOCATOR_MACROS_SVH
`define BLOCK_BUFFER_CACHE_ALLOCATOR_MACROS_SVH
// Same-cycle implication under reset.
`define BBCA_ASSERT_IMPL(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
		else $error("bbca assertion failed");
// Next-cycle implication under reset.
`define BBCA_ASSERT_NEXT(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
		else $error("bbca assertion failed");
`endif

### design/bbca_pkg.sv
// Types and codes for the buffer cache allocator.
// No dependencies.
package bbca_pkg;
	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_MISS      = 3'd1;
	localparam logic [2:0] ST_WRITEBACK = 3'd2;
	localparam logic [2:0] ST_BUSY      = 3'd3;
	localparam logic [2:0] ST_STARVED   = 3'd4;
	localparam logic [2:0] ST_RELEASED  = 3'd5;

	localparam logic OP_GET     = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [7:0]  device;
		logic [31:0] block;
		logic [4:0]  buffer_index;
		logic        mark_delayed;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  buffer_out;
		logic [7:0]  device_out;
		logic [31:0] block_out;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic retag;
		logic lock_set;
		logic lock_clr;
		logic dly_set;
		logic dly_clr;
	} tag_ctl_t;

	typedef struct packed {
		logic rm_head;
		logic rm_key;
		logic load;
	} lru_ctl_t;
endpackage

### design/block_buffer_cache_allocator.sv
// Buffer cache allocator top: tag cells, free-list cell chain, control FSM.
// Depends on bbca_pkg, bbca_tag_cell, bbca_lru_cell and the macro header.
// Usage: one request transaction (req_valid/req_ready, payload req) is a get
// (device, block) or a release (buffer_index, mark_delayed). Each request gives
// one or more response transactions on rsp_valid/rsp_ready; the final one has
// last set. A get is matched against all tag cells in S_MATCH; S_GRANT then
// registers a hit, busy or starved response, or for a miss moves to S_TAKE,
// which takes buffers from the free-list head, giving one writeback response
// per delayed buffer ahead of the miss response. A release is answered from
// S_REL. The free list is updated in place through the cell chain. Requests
// are taken one at a time, while the previous final response may still wait
// in the output register. A stalled receiver holds the output register and
// the FSM waits.
// Reset leaves all buffers untagged, unlocked, clean and free, in ascending
// order on the free list; no clearing pass is needed.
`include "block_buffer_cache_allocator_macros.svh"
module block_buffer_cache_allocator #(
	parameter int NUM_BUFFERS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bbca_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bbca_pkg::rsp_t rsp
);
	localparam int BW = $clog2(NUM_BUFFERS);
	localparam int CW = $clog2(NUM_BUFFERS + 1);
	localparam int IW = (BW > 5) ? BW : 5;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MATCH = 5'b00010,
		S_GRANT = 5'b00100,
		S_TAKE  = 5'b01000,
		S_REL   = 5'b10000
	} state_t;

	state_t         state_q, state_d;
	bbca_pkg::req_t req_q;
	bbca_pkg::rsp_t rsp_q, rsp_d;
	logic           rsp_valid_q, emit;
	logic [CW-1:0]  free_cnt_q, free_cnt_d;
	logic           hit_q;
	logic [BW-1:0]  hidx_q;

	logic [7:0]  tdev [NUM_BUFFERS];
	logic [31:0] tblk [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] tlock, tdly, thit;
	bbca_pkg::tag_ctl_t tctl [NUM_BUFFERS];

	logic [BW-1:0] lval [NUM_BUFFERS];
	logic [NUM_BUFFERS:0] seen;
	bbca_pkg::lru_ctl_t lctl;
	logic [CW-1:0] load_pos;
	logic [BW-1:0] load_val;

	logic          hit_c, found;
	logic [BW-1:0] hidx_c, ridx, rd_idx, head;
	logic          ridx_ok, out_free;
	logic [IW-1:0] ridx_w;
	logic [6:0]    ridx_e;

	// per-buffer control selects
	logic [BW-1:0] sel;
	logic retag, lock_set, lock_clr, dly_set, dly_clr;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign head      = lval[0];

	assign ridx_w  = IW'(req_q.buffer_index);
	assign ridx    = ridx_w[BW-1:0];
	assign ridx_e  = 7'(req_q.buffer_index);
	assign ridx_ok = ridx_e < 7'(NUM_BUFFERS);
	assign rd_idx  = (state_q == S_REL) ? ridx : head;

	for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_tag
		always_comb begin
			tctl[i].retag    = retag    && (sel == BW'(i));
			tctl[i].lock_set = lock_set && (sel == BW'(i));
			tctl[i].lock_clr = lock_clr && (sel == BW'(i));
			tctl[i].dly_set  = dly_set  && (sel == BW'(i));
			tctl[i].dly_clr  = dly_clr  && (sel == BW'(i));
		end
		bbca_tag_cell u_tag (
			.clk(clk), .arst_n(arst_n), .ctl(tctl[i]),
			.dev_in(req_q.device), .blk_in(req_q.block),
			.dev(tdev[i]), .blk(tblk[i]), .locked(tlock[i]),
			.delayed(tdly[i]), .hit(thit[i])
		);
	end

	assign seen[0] = 1'b0;
	for (genvar j = 0; j < NUM_BUFFERS; j++) begin : g_lru
		bbca_lru_cell #(.BW(BW), .CW(CW), .POS(j)) u_lru (
			.clk(clk), .arst_n(arst_n), .ctl(lctl), .load_pos(load_pos),
			.load_val(load_val), .key(hidx_q),
			.nbr((j == NUM_BUFFERS - 1) ? lval[j] : lval[(j + 1) % NUM_BUFFERS]),
			.seen_in(seen[j]), .seen_out(seen[j+1]), .val(lval[j])
		);
	end

	// lowest matching buffer wins
	always_comb begin
		found  = 1'b0;
		hidx_c = '0;
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			if (thit[i] && !found) begin
				found  = 1'b1;
				hidx_c = BW'(i);
			end
		end
		hit_c = found;
	end

	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		rsp_d      = rsp_q;
		free_cnt_d = free_cnt_q;
		sel        = hidx_q;
		retag      = 1'b0;
		lock_set   = 1'b0;
		lock_clr   = 1'b0;
		dly_set    = 1'b0;
		dly_clr    = 1'b0;
		lctl       = '0;
		load_pos   = free_cnt_q;
		load_val   = rd_idx;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid)
					state_d = (req.op == bbca_pkg::OP_RELEASE) ? S_REL : S_MATCH;
			end
			S_MATCH: state_d = S_GRANT;
			S_GRANT: begin
				if (out_free) begin
					emit             = 1'b1;
					rsp_d.device_out = req_q.device;
					rsp_d.block_out  = req_q.block;
					rsp_d.buffer_out = 5'(hidx_q);
					rsp_d.last       = 1'b1;
					state_d          = S_IDLE;
					if (hit_q && tlock[hidx_q]) begin
						rsp_d.status = bbca_pkg::ST_BUSY;
					end else if (hit_q) begin
						rsp_d.status = bbca_pkg::ST_HIT;
						lock_set     = 1'b1;
						lctl.rm_key  = 1'b1;
						free_cnt_d   = free_cnt_q - 1'b1;
					end else if (free_cnt_q == '0) begin
						rsp_d.status     = bbca_pkg::ST_STARVED;
						rsp_d.buffer_out = '0;
					end else begin
						emit    = 1'b0;
						state_d = S_TAKE;
					end
				end
			end
			S_TAKE: begin
				if (out_free) begin
					emit             = 1'b1;
					sel              = head;
					rsp_d.buffer_out = 5'(head);
					lctl.rm_head     = 1'b1;
					if (tdly[head]) begin
						// write back, then requeue at the tail
						rsp_d.status     = bbca_pkg::ST_WRITEBACK;
						rsp_d.device_out = tdev[head];
						rsp_d.block_out  = tblk[head];
						rsp_d.last       = 1'b0;
						dly_clr          = 1'b1;
						lctl.load        = 1'b1;
						load_pos         = free_cnt_q - 1'b1;
					end else begin
						rsp_d.status     = bbca_pkg::ST_MISS;
						rsp_d.device_out = req_q.device;
						rsp_d.block_out  = req_q.block;
						rsp_d.last       = 1'b1;
						retag            = 1'b1;
						lock_set         = 1'b1;
						free_cnt_d       = free_cnt_q - 1'b1;
						state_d          = S_IDLE;
					end
				end
			end
			S_REL: begin
				if (out_free) begin
					emit             = 1'b1;
					sel              = ridx;
					rsp_d.status     = bbca_pkg::ST_RELEASED;
					rsp_d.buffer_out = req_q.buffer_index;
					rsp_d.last       = 1'b1;
					rsp_d.device_out = ridx_ok ? tdev[rd_idx] : 8'd0;
					rsp_d.block_out  = ridx_ok ? tblk[rd_idx] : 32'd0;
					state_d          = S_IDLE;
					if (ridx_ok && tlock[rd_idx]) begin
						lock_clr   = 1'b1;
						dly_set    = req_q.mark_delayed;
						lctl.load  = 1'b1;
						free_cnt_d = free_cnt_q + 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			free_cnt_q  <= CW'(NUM_BUFFERS);
			hit_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			free_cnt_q <= free_cnt_d;
			if (emit) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			if (state_q == S_MATCH) hit_q <= hit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_q <= req;
		if (state_q == S_MATCH) hidx_q <= hidx_c;
		if (emit) rsp_q <= rsp_d;
	end

	`BBCA_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, free_cnt_q <= CW'(NUM_BUFFERS))
	`BBCA_ASSERT_NEXT(a_accept_busy, clk, arst_n, req_valid && req_ready, state_q != S_IDLE)
	`BBCA_ASSERT_IMPL(a_take_nonempty, clk, arst_n, state_q == S_TAKE, free_cnt_q != '0)
endmodule

### design/bbca_tag_cell.sv
// One buffer's tag and flags with its own associative compare.
// Depends on bbca_pkg.
module bbca_tag_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bbca_pkg::tag_ctl_t ctl,
	input  logic [7:0]        dev_in,
	input  logic [31:0]       blk_in,
	output logic [7:0]        dev,
	output logic [31:0]       blk,
	output logic              locked,
	output logic              delayed,
	output logic              hit
);
	logic present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev       <= '0;
			blk       <= '0;
			present_q <= 1'b0;
			locked    <= 1'b0;
			delayed   <= 1'b0;
		end else begin
			if (ctl.retag) begin
				dev       <= dev_in;
				blk       <= blk_in;
				present_q <= 1'b1;
			end
			if (ctl.lock_set) locked <= 1'b1;
			else if (ctl.lock_clr) locked <= 1'b0;
			if (ctl.dly_set) delayed <= 1'b1;
			else if (ctl.dly_clr) delayed <= 1'b0;
		end
	end

	assign hit = present_q && (dev == dev_in) && (blk == blk_in);
endmodule

### design/bbca_lru_cell.sv
// One position of the free list; shifts toward the head on removal.
// Depends on bbca_pkg.
module bbca_lru_cell #(
	parameter int BW  = 5,
	parameter int CW  = 6,
	parameter int POS = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bbca_pkg::lru_ctl_t ctl,
	input  logic [CW-1:0]      load_pos,
	input  logic [BW-1:0]      load_val,
	input  logic [BW-1:0]      key,
	input  logic [BW-1:0]      nbr,
	input  logic               seen_in,
	output logic               seen_out,
	output logic [BW-1:0]      val
);
	logic shift, ld;

	assign seen_out = seen_in | (val == key);
	assign shift    = ctl.rm_head | (ctl.rm_key & seen_out);
	assign ld       = ctl.load && (load_pos == CW'(POS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) val <= BW'(POS);
		else if (ld) val <= load_val;
		else if (shift) val <= nbr;
	end
endmodule
